// ===== rtl/core/lidar_frame_deframe_repack_unit_macros.svh =====
// assertion macros used by the checker file
`ifndef LIDAR_FRAME_DEFRAME_REPACK_UNIT_MACROS_SVH
`define LIDAR_FRAME_DEFRAME_REPACK_UNIT_MACROS_SVH

// property that must hold on every clock edge out of reset
`define LFDR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define LFDR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/lfdr_pkg.sv =====
// ----------------------------------------------------------------------------
// lfdr_pkg
// Shared constants and types of the lidar frame deframe and repack unit.
// ----------------------------------------------------------------------------
package lfdr_pkg;

	// framing bytes
	localparam logic [7:0] SYNC_A = 8'h54;
	localparam logic [7:0] SYNC_B = 8'h2C;

	// body store limits
	localparam int BODY_MAX  = 47;
	localparam int BODY_MIN  = 40;
	localparam int BODY_LAST = 38;
	localparam int BODY_FIRST = 2;
	localparam int CNT_W     = $clog2(BODY_MAX + 1);

	// emitted frame layout: two header bytes then the kept body bytes
	localparam int FRAME_OUT = 28;
	localparam int HDR_NUM   = 2;
	localparam int SLOT_NUM  = FRAME_OUT - HDR_NUM;
	localparam int OUT_IDX_W = $clog2(FRAME_OUT);
	localparam int SLOT_W    = $clog2(SLOT_NUM);

	// frame banks between front and back
	localparam int NBANK  = 4;
	localparam int BANK_W = $clog2(NBANK);
	localparam int OCC_W  = $clog2(NBANK + 1);
	localparam int ADDR_W = BANK_W + SLOT_W;

	// output queue
	localparam int FIFO_DEPTH = 4;
	localparam int FPTR_W     = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	// write request from the front into the bank memory
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_t;

	// bank queue status seen by front and back
	typedef struct packed {
		logic [BANK_W-1:0] wr_bank;
		logic [BANK_W-1:0] rd_bank;
		logic              full;
		logic              avail;
	} bank_st_t;

endpackage

// ===== rtl/core/lfdr_bank_ram.sv =====
// ----------------------------------------------------------------------------
// lfdr_bank_ram
// Frame bank memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lfdr_bank_ram
	import lfdr_pkg::*;
(
	input  logic              clk,
	input  wr_t               wr,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);

	logic [7:0] mem_q [2**ADDR_W];
	logic [7:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/lfdr_front.sv =====
// ----------------------------------------------------------------------------
// lfdr_front
// Header hunt, body framing and end detection; writes kept body bytes.
// ----------------------------------------------------------------------------
module lfdr_front
	import lfdr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       acc,
	input  logic [7:0] rx_byte,
	input  bank_st_t   st,
	output wr_t        wr,
	output logic       commit
);

	logic              in_frame_q, in_frame_d;
	logic              hdr_half_q, hdr_half_d;
	logic              end_half_q, end_half_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [1:0]        ph_q, ph_d;
	logic [SLOT_W-1:0] slot_q, slot_d;
	logic [CNT_W-1:0]  cnt_inc;
	logic              keep;

	// body index kept in the output: 2..38, minus multiples of three past 3
	assign cnt_inc = cnt_q + CNT_W'(1);
	assign keep    = (cnt_q >= CNT_W'(BODY_FIRST)) && (cnt_q <= CNT_W'(BODY_LAST))
		&& ((cnt_q < CNT_W'(4)) || (ph_q != 2'd0));

	// next state per accepted byte
	always_comb begin
		in_frame_d = in_frame_q;
		hdr_half_d = hdr_half_q;
		end_half_d = end_half_q;
		cnt_d      = cnt_q;
		ph_d       = ph_q;
		slot_d     = slot_q;
		commit     = 1'b0;
		wr.en      = 1'b0;
		wr.addr    = {st.wr_bank, slot_q};
		wr.data    = rx_byte;
		if (acc) begin
			if (!in_frame_q) begin
				// hunting for the header pair
				if (hdr_half_q && (rx_byte == SYNC_B)) begin
					hdr_half_d = 1'b0;
					in_frame_d = 1'b1;
					end_half_d = 1'b0;
					cnt_d      = '0;
					ph_d       = 2'd0;
					slot_d     = '0;
				end else begin
					hdr_half_d = (rx_byte == SYNC_A);
				end
			end else if (end_half_q && (rx_byte == SYNC_B)) begin
				// frame complete, next frame starts at once
				commit     = 1'b1;
				end_half_d = 1'b0;
				cnt_d      = '0;
				ph_d       = 2'd0;
				slot_d     = '0;
			end else if (end_half_q && (cnt_q >= CNT_W'(BODY_MAX))) begin
				// end pending at full store failed: drop, rehunt this byte
				in_frame_d = 1'b0;
				end_half_d = 1'b0;
				cnt_d      = '0;
				hdr_half_d = (rx_byte == SYNC_A);
			end else begin
				// store one body byte
				end_half_d = 1'b0;
				wr.en      = keep;
				cnt_d      = cnt_inc;
				ph_d       = (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
				if (keep) begin
					slot_d = slot_q + SLOT_W'(1);
				end
				if ((cnt_inc >= CNT_W'(BODY_MIN)) && (rx_byte == SYNC_A)) begin
					end_half_d = 1'b1;
				end else if (cnt_inc >= CNT_W'(BODY_MAX)) begin
					in_frame_d = 1'b0;
					hdr_half_d = 1'b0;
					cnt_d      = '0;
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			hdr_half_q <= 1'b0;
			end_half_q <= 1'b0;
			cnt_q      <= '0;
			ph_q       <= 2'd0;
			slot_q     <= '0;
		end else begin
			in_frame_q <= in_frame_d;
			hdr_half_q <= hdr_half_d;
			end_half_q <= end_half_d;
			cnt_q      <= cnt_d;
			ph_q       <= ph_d;
			slot_q     <= slot_d;
		end
	end

endmodule

// ===== rtl/core/lfdr_bank_ctl.sv =====
// ----------------------------------------------------------------------------
// lfdr_bank_ctl
// Queue of finished frame banks between front and back.
// ----------------------------------------------------------------------------
module lfdr_bank_ctl
	import lfdr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     commit,
	input  logic     done,
	output bank_st_t st
);

	logic [BANK_W-1:0] wr_bank_q;
	logic [BANK_W-1:0] rd_bank_q;
	logic [OCC_W-1:0]  occ_q;

	// bank pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_bank_q <= '0;
			rd_bank_q <= '0;
			occ_q     <= '0;
		end else begin
			if (commit) begin
				wr_bank_q <= wr_bank_q + BANK_W'(1);
			end
			if (done) begin
				rd_bank_q <= rd_bank_q + BANK_W'(1);
			end
			if (commit && !done) begin
				occ_q <= occ_q + OCC_W'(1);
			end else if (done && !commit) begin
				occ_q <= occ_q - OCC_W'(1);
			end
		end
	end

	assign st.wr_bank = wr_bank_q;
	assign st.rd_bank = rd_bank_q;
	assign st.full    = (occ_q == OCC_W'(NBANK));
	assign st.avail   = (occ_q != '0);

endmodule

// ===== rtl/core/lfdr_back.sv =====
// ----------------------------------------------------------------------------
// lfdr_back
// Frame emission sequencer with bank read stage and output queue.
// ----------------------------------------------------------------------------
module lfdr_back
	import lfdr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  bank_st_t          st,
	input  logic [7:0]        rd_data,
	output logic              rd_en,
	output logic [ADDR_W-1:0] rd_addr,
	output logic              done,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              last_of_frame
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} oitem_t;

	logic [OUT_IDX_W-1:0] idx_q;
	logic                 v_s1;
	logic                 hdr_s1;
	logic [7:0]           hbyte_s1;
	logic                 last_s1;
	oitem_t               fifo_q [FIFO_DEPTH];
	logic [FPTR_W-1:0]    wptr_q, rptr_q;
	logic [FCNT_W-1:0]    fcnt_q;
	logic [FCNT_W:0]      room_sum;
	logic                 issue;
	logic                 is_last;
	logic                 push, pop;
	oitem_t               push_item;

	// issue one output position when a frame waits and the queue has room
	assign room_sum = {1'b0, fcnt_q} + (FCNT_W + 1)'(v_s1);
	assign issue    = st.avail && (room_sum < (FCNT_W + 1)'(FIFO_DEPTH));
	assign is_last  = (idx_q == OUT_IDX_W'(FRAME_OUT - 1));
	assign done     = issue && is_last;
	assign rd_en    = issue;
	assign rd_addr  = {st.rd_bank, SLOT_W'(idx_q - OUT_IDX_W'(HDR_NUM))};

	// position counter within the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (issue) begin
			idx_q <= is_last ? '0 : idx_q + OUT_IDX_W'(1);
		end
	end

	// read stage: header bytes bypass the memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			hdr_s1   <= (idx_q < OUT_IDX_W'(HDR_NUM));
			hbyte_s1 <= (idx_q == '0) ? SYNC_A : SYNC_B;
			last_s1  <= is_last;
		end
	end

	// output queue
	assign push           = v_s1;
	assign pop            = out_valid && !out_stall;
	assign push_item.data = hdr_s1 ? hbyte_s1 : rd_data;
	assign push_item.last = last_s1;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fcnt_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + FPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + FPTR_W'(1);
			end
			if (push && !pop) begin
				fcnt_q <= fcnt_q + FCNT_W'(1);
			end else if (pop && !push) begin
				fcnt_q <= fcnt_q - FCNT_W'(1);
			end
		end
	end

	assign out_valid     = (fcnt_q != '0);
	assign out_byte      = fifo_q[rptr_q].data;
	assign last_of_frame = fifo_q[rptr_q].last;

endmodule

// ===== rtl/core/lidar_frame_deframe_repack_unit.sv =====
// ----------------------------------------------------------------------------
// lidar_frame_deframe_repack_unit
// Lidar UART deframer: hunts 0x54 0x2C, collects the body, emits 28 bytes.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  input    in_valid / in_stall   rx_byte
//  output   out_valid / out_stall out_byte, last_of_frame
//
// One input byte is taken per cycle while a free frame bank exists.
// A finished frame leaves as 28 bytes, one per cycle while out_stall is low,
// passing from its bank through the bank read stage and a four-entry output
// queue. Four frame banks let input continue during emission.
// in_stall rises only when all four banks hold frames not yet read out.
// Reset is asynchronous and clears all control state; banks need no clearing.
module lidar_frame_deframe_repack_unit
	import lfdr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_of_frame
);

	bank_st_t          st;
	wr_t               wr;
	logic              commit;
	logic              done;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;
	logic              acc;

	// input accept
	assign in_stall = st.full;
	assign acc      = in_valid && !in_stall;

	lfdr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.rx_byte (rx_byte),
		.st      (st),
		.wr      (wr),
		.commit  (commit)
	);

	lfdr_bank_ctl u_bank_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (commit),
		.done   (done),
		.st     (st)
	);

	lfdr_bank_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	lfdr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.st            (st),
		.rd_data       (rd_data),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.done          (done),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.last_of_frame (last_of_frame)
	);

endmodule

// ===== rtl/core/lfdr_checker.sv =====
// ----------------------------------------------------------------------------
// lfdr_checker
// Port-level checks of the deframer output stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "lidar_frame_deframe_repack_unit_macros.svh"

module lfdr_checker
	import lfdr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       last_of_frame
);

	logic [OUT_IDX_W-1:0] pos_q;
	logic                 oacc;

	// position of the next output item within its frame
	assign oacc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (oacc) begin
			pos_q <= (pos_q == OUT_IDX_W'(FRAME_OUT - 1)) ? '0 : pos_q + OUT_IDX_W'(1);
		end
	end

	// stalled output holds
	`LFDR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(last_of_frame), "stalled output item changed")

	// last flag marks exactly the final byte of each frame
	`LFDR_ASSERT(a_last_pos, !out_valid || (last_of_frame == (pos_q == OUT_IDX_W'(FRAME_OUT - 1))), "last_of_frame out of place")

	// every frame opens with the header pair
	`LFDR_ASSERT(a_hdr_a, !out_valid || (pos_q != '0) || (out_byte == SYNC_A), "first byte not 0x54")
	`LFDR_ASSERT(a_hdr_b, !out_valid || (pos_q != OUT_IDX_W'(1)) || (out_byte == SYNC_B), "second byte not 0x2C")

endmodule

bind lidar_frame_deframe_repack_unit lfdr_checker u_lfdr_checker (.*);
